>>> design/srl_pkg.sv
// ----------------------------------------------------------------------------
// S-record loader package
// Shared types and constants for the S1/S9 record loader.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int SRL_COUNT_BITS = 16;
  localparam int SRL_ADDR_W     = 16;
  localparam int SRL_BYTE_W     = 8;
  localparam int SRL_CNT_OUT_W  = 16;

  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN,
    PH_AHI,
    PH_ALO,
    PH_DATA,
    PH_CSUM,
    PH_DONE
  } srl_phase_t;

  typedef enum logic [1:0] {
    EV_WRITE  = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_ABORT  = 2'd2,
    EV_END    = 2'd3
  } srl_event_t;

  typedef struct packed {
    srl_event_t                 event_res;
    logic [SRL_ADDR_W-1:0]      address;
    logic [SRL_BYTE_W-1:0]      data_byte;
    logic [SRL_CNT_OUT_W-1:0]   records_loaded;
    logic [SRL_ADDR_W-1:0]      start_address;
    logic [SRL_BYTE_W-1:0]      calc_checksum;
    logic [SRL_BYTE_W-1:0]      expected_checksum;
  } srl_result_t;

endpackage

>>> design/srl_parser.sv
// ----------------------------------------------------------------------------
// S-record parser
// Holds the record state and works out one character per cycle.
// ----------------------------------------------------------------------------
module srl_parser
  import srl_pkg::*;
#(
  parameter int COUNT_BITS = SRL_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  char_fire,
  input  logic [7:0]            char_in,
  output logic                  res_valid,
  output srl_result_t           res
);

  localparam int CNT_W = (COUNT_BITS < SRL_CNT_OUT_W) ? COUNT_BITS : SRL_CNT_OUT_W;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  srl_phase_t              phase_r, phase_nxt;
  logic                    pend_r, pend_nxt;
  logic [3:0]              hi_r, hi_nxt;
  logic [7:0]              fidx_r, fidx_nxt;
  logic [7:0]              len_r, len_nxt;
  logic [SRL_ADDR_W-1:0]   wp_r, wp_nxt;
  logic [7:0]              sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SRL_ADDR_W-1:0]   origin_first_r, origin_first_nxt;
  logic                    seen_r, seen_nxt;

  logic [7:0]              byte_val;
  logic [7:0]              dcount;
  logic [7:0]              fidx_inc;
  logic [7:0]              calc;
  logic [SRL_ADDR_W-1:0]   origin;

  always_comb begin
    byte_val = {hi_r, hex_value(char_in)};
    dcount   = (len_r >= 8'd3) ? 8'(len_r - 8'd3) : 8'd0;
    fidx_inc = 8'(fidx_r + 8'd1);
    calc     = ~sum_r;
    origin   = SRL_ADDR_W'(wp_r - {{(SRL_ADDR_W-8){1'b0}}, fidx_r});

    phase_nxt        = phase_r;
    pend_nxt         = pend_r;
    hi_nxt           = hi_r;
    fidx_nxt         = fidx_r;
    len_nxt          = len_r;
    wp_nxt           = wp_r;
    sum_nxt          = sum_r;
    count_nxt        = count_r;
    origin_first_nxt = origin_first_r;
    seen_nxt         = seen_r;
    res_valid        = 1'b0;
    res              = '0;

    if (char_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (char_in == CH_S) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (char_in == CH_ONE) begin
            phase_nxt = PH_LEN;
            pend_nxt  = 1'b0;
            hi_nxt    = 4'd0;
            fidx_nxt  = 8'd0;
            len_nxt   = 8'd0;
            sum_nxt   = 8'd0;
          end else if (char_in == CH_NINE) begin
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            res.event_res = EV_END;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DONE: begin
        end
        default: begin
          if (!pend_r) begin
            hi_nxt   = hex_value(char_in);
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            case (phase_r)
              PH_LEN: begin
                len_nxt   = byte_val;
                sum_nxt   = byte_val;
                phase_nxt = PH_AHI;
              end
              PH_AHI: begin
                wp_nxt    = {byte_val, 8'd0};
                sum_nxt   = 8'(sum_r + byte_val);
                phase_nxt = PH_ALO;
              end
              PH_ALO: begin
                wp_nxt    = {wp_r[15:8], byte_val};
                sum_nxt   = 8'(sum_r + byte_val);
                phase_nxt = (dcount != 8'd0) ? PH_DATA : PH_CSUM;
              end
              PH_DATA: begin
                res_valid     = 1'b1;
                res.event_res = EV_WRITE;
                res.address   = wp_r;
                res.data_byte = byte_val;
                sum_nxt       = 8'(sum_r + byte_val);
                wp_nxt        = SRL_ADDR_W'(wp_r + 1'b1);
                fidx_nxt      = fidx_inc;
                if (fidx_inc >= dcount) begin
                  phase_nxt = PH_CSUM;
                end
              end
              PH_CSUM: begin
                res_valid             = 1'b1;
                res.address           = origin;
                res.calc_checksum     = calc;
                res.expected_checksum = byte_val;
                if (calc == byte_val) begin
                  if (count_r != {CNT_W{1'b1}}) begin
                    count_nxt = CNT_W'(count_r + 1'b1);
                  end
                  if (!seen_r) begin
                    seen_nxt         = 1'b1;
                    origin_first_nxt = origin;
                  end
                  phase_nxt     = PH_HUNT;
                  res.event_res = EV_ACCEPT;
                end else begin
                  phase_nxt     = PH_DONE;
                  res.event_res = EV_ABORT;
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end

    res.records_loaded = SRL_CNT_OUT_W'(count_nxt);
    res.start_address  = origin_first_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      pend_r         <= 1'b0;
      hi_r           <= 4'd0;
      fidx_r         <= 8'd0;
      len_r          <= 8'd0;
      wp_r           <= '0;
      sum_r          <= 8'd0;
      count_r        <= '0;
      origin_first_r <= '0;
      seen_r         <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      pend_r         <= pend_nxt;
      hi_r           <= hi_nxt;
      fidx_r         <= fidx_nxt;
      len_r          <= len_nxt;
      wp_r           <= wp_nxt;
      sum_r          <= sum_nxt;
      count_r        <= count_nxt;
      origin_first_r <= origin_first_nxt;
      seen_r         <= seen_nxt;
    end
  end

endmodule

>>> design/srl_out_buf.sv
// ----------------------------------------------------------------------------
// S-record loader result buffer
// Two-entry result register that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module srl_out_buf
  import srl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  srl_result_t  push_res,
  output logic         has_room,
  output logic         out_valid,
  input  logic         out_ready,
  output srl_result_t  head
);

  logic [1:0]   cnt_r, cnt_nxt;
  srl_result_t  slot0_r, slot0_nxt;
  srl_result_t  slot1_r, slot1_nxt;
  logic         pop;

  assign has_room  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign head      = slot0_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop && push) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = push_res;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_res;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = 2'(cnt_r - 1'b1);
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = push_res;
      end else begin
        slot1_nxt = push_res;
      end
      cnt_nxt = 2'(cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

>>> design/srecord_s1_loader.sv
// ----------------------------------------------------------------------------
// S-record S1/S9 loader
// Parses an ASCII S-record stream and issues memory write and status words.
// ----------------------------------------------------------------------------
// The input channel carries one received ASCII character per word. Text is
// skipped until an S; an S1 record yields one write word per data byte, then
// a record-accepted or checksum-abort word, and S9 yields an end-of-load
// word. After an end or an abort every further character is taken and
// dropped until reset.
// The parser state updates on the edge that accepts a character, and any
// result is written into the result buffer on the same edge, so one
// character can be taken every cycle while in_ready is high.
// A two-entry result buffer lets the block take a character while a result
// still waits; in_ready falls only when both entries are full, so a stalled
// receiver holds back the input after two pending results.
// Reset is synchronous and active low: it returns the parser to hunting for
// an S, clears the record count and start address and empties the buffer.
// ----------------------------------------------------------------------------
module srecord_s1_loader
  import srl_pkg::*;
#(
  parameter int COUNT_BITS = SRL_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_event_res,
  output logic [SRL_ADDR_W-1:0]     out_address,
  output logic [SRL_BYTE_W-1:0]     out_data_byte,
  output logic [SRL_CNT_OUT_W-1:0]  out_records_loaded,
  output logic [SRL_ADDR_W-1:0]     out_start_address,
  output logic [SRL_BYTE_W-1:0]     out_calc_checksum,
  output logic [SRL_BYTE_W-1:0]     out_expected_checksum
);

  logic         char_fire;
  logic         res_valid;
  srl_result_t  res;
  srl_result_t  head;

  assign char_fire = in_valid && in_ready;

  srl_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_fire (char_fire),
    .char_in   (in_char_in),
    .res_valid (res_valid),
    .res       (res)
  );

  srl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_event_res         = head.event_res;
  assign out_address           = head.address;
  assign out_data_byte         = head.data_byte;
  assign out_records_loaded    = head.records_loaded;
  assign out_start_address     = head.start_address;
  assign out_calc_checksum     = head.calc_checksum;
  assign out_expected_checksum = head.expected_checksum;

endmodule

>>> design/srl_checker.sv
// ----------------------------------------------------------------------------
// S-record loader checker
// Port-level assertions on the loader, bound to the top level.
// ----------------------------------------------------------------------------
module srl_checker
  import srl_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_valid,
  input logic         out_ready,
  input logic [1:0]   out_event_res,
  input logic [15:0]  out_address,
  input logic [7:0]   out_data_byte,
  input logic [15:0]  out_records_loaded
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_address) && $stable(out_data_byte))
    else $error("stalled result word changed");

  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_event_res == EV_END || out_event_res == EV_ABORT)
      |=> !out_valid)
    else $error("result word after end of load or abort");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_END |-> out_address == 16'd0
      && out_data_byte == 8'd0)
    else $error("end of load word carries an address or data");

  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ACCEPT |-> out_records_loaded != 16'd0)
    else $error("accepted record not counted");

endmodule

bind srecord_s1_loader srl_checker u_srl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_event_res      (out_event_res),
  .out_address        (out_address),
  .out_data_byte      (out_data_byte),
  .out_records_loaded (out_records_loaded)
);
